// ===== src/lss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and field widths for the byte-wide stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int VALUE_W   = 8;
    localparam int ACTION_W  = 2;
    localparam int FIELD_W   = 7;   // position and fill fields
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 24;  // data, position, fill, padded to bytes
    localparam int M_TUSER_W = 8;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - 2 * FIELD_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_SEARCH = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOTFOUND  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE = 4'b0001,
        FSM_POP  = 4'b0010,
        FSM_SCAN = 4'b0100,
        FSM_DONE = 4'b1000
    } fsm_t;

endpackage
`default_nettype wire

// ===== src/lss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lss_ram
// Simple dual-port entry store: one write port, one read port with
// registered read data. No reset on the contents.
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                        aclk,
    input  wire                        wr_en,
    input  wire  [AW-1:0]              wr_addr,
    input  wire  [lss_pkg::VALUE_W-1:0] wr_data,
    input  wire                        rd_en,
    input  wire  [AW-1:0]              rd_addr,
    output logic [lss_pkg::VALUE_W-1:0] rd_data
);
    import lss_pkg::*;

    logic [VALUE_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/lifo_stack_with_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Byte-wide LIFO stack with push, pop, clear and a linear search from the
// bottom. One result beat per request beat.
//
//  channel | dir | tdata (low bit up)              | tuser
//  --------+-----+---------------------------------+------------------
//  s_      | in  | value[7:0]                      | action[1:0]
//  m_      | out | data[7:0] position[14:8]        | status[2:0]
//          |     | fill[21:15] zero[23:22]         |
//
// Push and clear go straight to the result register; pop first reads one
// entry from the entry store; search reads and compares one stored entry
// per cycle through the single read port.
// Reset clears the fill count and the control; entry contents are kept.
// A new request beat is taken while a result beat still waits on m_tready;
// its result is held until the output register frees.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
    parameter int DEPTH = 64
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [lss_pkg::S_TDATA_W-1:0] s_tdata,  // value[7:0]
    input  wire  [lss_pkg::S_TUSER_W-1:0] s_tuser,  // action[1:0]
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [lss_pkg::M_TDATA_W-1:0] m_tdata,  // data, position, fill
    output logic [lss_pkg::M_TUSER_W-1:0] m_tuser   // status[2:0]
);
    import lss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fsm_t                state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [VALUE_W-1:0]  res_data_reg, res_data_next;
    logic [FIELD_W-1:0]  res_pos_reg, res_pos_next;
    status_t             res_status_reg, res_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic               s_fire;
    action_t            s_action;
    logic               full;
    logic               empty;
    logic [CW-1:0]      cnt_dec;
    logic [CW-1:0]      cmp_idx_inc;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    assign s_tready    = (state_reg == FSM_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign s_action    = action_t'(s_tuser[ACTION_W-1:0]);
    assign full        = (count_reg == CW'(DEPTH));
    assign empty       = (count_reg == '0);
    assign cnt_dec     = count_reg - CW'(1);
    assign cmp_idx_inc = cmp_idx_reg + CW'(1);
    assign wr_addr     = count_reg[AW-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    lss_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[VALUE_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        value_next      = value_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = cnt_dec[AW-1:0];

        // drop the beat once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    value_next      = s_tdata[VALUE_W-1:0];
                    res_data_next   = '0;
                    res_pos_next    = '0;
                    res_status_next = ST_OK;
                    state_next      = FSM_DONE;
                    unique case (s_action)
                        ACT_PUSH: begin
                            if (full) begin
                                res_status_next = ST_OVERFLOW;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_POP: begin
                            if (empty) begin
                                res_status_next = ST_UNDERFLOW;
                            end else begin
                                rd_en      = 1'b1;
                                count_next = cnt_dec;
                                state_next = FSM_POP;
                            end
                        end
                        ACT_CLEAR: begin
                            count_next = '0;
                        end
                        ACT_SEARCH: begin
                            if (empty) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                scan_cnt_next = '0;
                                cmp_vld_next  = 1'b0;
                                state_next    = FSM_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FSM_POP: begin
                res_data_next = rd_data;
                state_next    = FSM_DONE;
            end
            FSM_SCAN: begin
                // issue the next read while comparing the previous one
                rd_addr       = scan_cnt_reg[AW-1:0];
                rd_en         = (scan_cnt_reg < count_reg);
                cmp_vld_next  = rd_en;
                cmp_idx_next  = scan_cnt_reg;
                if (rd_en) begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                if (cmp_vld_reg) begin
                    if (rd_data == value_reg) begin
                        res_pos_next    = FIELD_W'(cmp_idx_inc);
                        res_status_next = ST_OK;
                        cmp_vld_next    = 1'b0;
                        state_next      = FSM_DONE;
                    end else if (cmp_idx_inc == count_reg) begin
                        res_status_next = ST_NOTFOUND;
                        cmp_vld_next    = 1'b0;
                        state_next      = FSM_DONE;
                    end
                end
            end
            FSM_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, FIELD_W'(count_reg),
                                     res_pos_reg, res_data_reg};
                    m_tuser_next  = {{(M_TUSER_W - STATUS_W){1'b0}}, res_status_reg};
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg      <= value_next;
        scan_cnt_reg   <= scan_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_action == ACT_PUSH && !full) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the stack");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("entry store written and read in one cycle");

    a_cmp_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> state_reg == FSM_SCAN)
        else $error("compare pending outside scan");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg[STATUS_W-1:0] == ST_UNDERFLOW)
            |-> m_tdata_reg[VALUE_W + 2 * FIELD_W - 1:VALUE_W + FIELD_W] == '0)
        else $error("underflow reported with nonzero fill");
`endif

endmodule
`default_nettype wire
